// ===== rtl/lcvm_pkg.sv =====
// Shared types, constants and helper functions for the line clip and viewport map block.
package lcvm_pkg;

  localparam int CB = 12;
  localparam int DB = CB + 1;
  localparam int PB = 2 * CB;
  localparam int SW = PB + 2;
  localparam int DIV_LAT = PB;
  localparam int LATENCY = 2 * DIV_LAT + 5;
  localparam int IDX_BITS = 3;

  localparam logic [IDX_BITS-1:0] REG_WINDOW_LEFT = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_WINDOW_RIGHT = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_WINDOW_BOTTOM = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_WINDOW_TOP = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] REG_DEVICE_WIDTH_MAX = IDX_BITS'(4);
  localparam logic [IDX_BITS-1:0] REG_DEVICE_HEIGHT_MAX = IDX_BITS'(5);

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef struct packed {
    logic [CB-1:0] wl;
    logic [CB-1:0] wr;
    logic [CB-1:0] wb;
    logic [CB-1:0] wt;
    logic [CB-1:0] dwm;
    logic [CB-1:0] dhm;
  } cfg_t;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] x1;
    logic [CB-1:0] y1;
    logic [CB-1:0] x2;
    logic [CB-1:0] y2;
    logic          in1;
    logic          in2;
    logic          degen;
    logic [3:0]    en;
    logic [3:0]    neg;
  } side_t;

  typedef struct packed {
    logic          op;
    logic          vis;
    logic [CB-1:0] p0x;
    logic [CB-1:0] p0y;
    logic [CB-1:0] p1x;
    logic [CB-1:0] p1y;
  } sel_t;

  function automatic logic signed [DB-1:0] diff(input logic [CB-1:0] a,
                                                input logic [CB-1:0] b);
    diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [CB-1:0] mag(input logic signed [DB-1:0] v);
    logic signed [DB-1:0] n;
    n = -v;
    mag = v[DB-1] ? n[CB-1:0] : v[CB-1:0];
  endfunction

  function automatic logic between(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                   input logic [CB-1:0] e);
    between = !((a < e && b < e) || (a > e && b > e));
  endfunction

endpackage

// ===== rtl/lcvm_div.sv =====
// Pipelined restoring divider that retires one quotient bit per stage.
module lcvm_div (
  input  logic                    clk,
  input  logic [lcvm_pkg::PB-1:0] num,
  input  logic [lcvm_pkg::CB-1:0] den,
  output logic [lcvm_pkg::PB-1:0] quo
);

  logic [lcvm_pkg::PB-1:0] a [lcvm_pkg::PB+1];
  logic [lcvm_pkg::CB-1:0] r [lcvm_pkg::PB];
  logic [lcvm_pkg::CB-1:0] d [lcvm_pkg::PB];

  assign a[0] = num;
  assign r[0] = '0;
  assign d[0] = den;

  for (genvar s = 0; s < lcvm_pkg::PB; s++) begin : g_stage
    logic [lcvm_pkg::CB:0] trial;
    logic [lcvm_pkg::CB:0] rest;
    logic                  take;

    assign trial = {r[s], a[s][lcvm_pkg::PB-1]};
    assign take = trial >= {1'b0, d[s]};
    assign rest = take ? trial - {1'b0, d[s]} : trial;

    always_ff @(posedge clk) begin
      a[s+1] <= {a[s][lcvm_pkg::PB-2:0], take};
    end

    if (s < lcvm_pkg::PB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        r[s+1] <= rest[lcvm_pkg::CB-1:0];
        d[s+1] <= d[s];
      end
    end
  end

  assign quo = a[lcvm_pkg::PB];

endmodule

// ===== rtl/lcvm_setup.sv =====
// Edge crossing setup: differences, inside tests, crossing numerators and denominators.
module lcvm_setup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              op,
  input  logic [lcvm_pkg::CB-1:0]           x1,
  input  logic [lcvm_pkg::CB-1:0]           y1,
  input  logic [lcvm_pkg::CB-1:0]           x2,
  input  logic [lcvm_pkg::CB-1:0]           y2,
  input  lcvm_pkg::cfg_t                    cfg,
  output logic                              out_valid,
  output lcvm_pkg::side_t                   side,
  output logic [3:0][lcvm_pkg::PB-1:0]      num,
  output logic [3:0][lcvm_pkg::CB-1:0]      den
);

  logic signed [lcvm_pkg::DB-1:0] dx, dy;
  logic signed [lcvm_pkg::DB-1:0] t [4];
  logic [lcvm_pkg::CB-1:0]        mdx, mdy;
  lcvm_pkg::side_t                side_next;

  always_comb begin
    dx = lcvm_pkg::diff(x2, x1);
    dy = lcvm_pkg::diff(y2, y1);
    mdx = lcvm_pkg::mag(dx);
    mdy = lcvm_pkg::mag(dy);
    t[0] = lcvm_pkg::diff(cfg.wl, x1);
    t[1] = lcvm_pkg::diff(cfg.wr, x1);
    t[2] = lcvm_pkg::diff(cfg.wb, y1);
    t[3] = lcvm_pkg::diff(cfg.wt, y1);
    side_next.op = op;
    side_next.x1 = x1;
    side_next.y1 = y1;
    side_next.x2 = x2;
    side_next.y2 = y2;
    side_next.in1 = x1 >= cfg.wl && x1 <= cfg.wr && y1 >= cfg.wb && y1 <= cfg.wt;
    side_next.in2 = x2 >= cfg.wl && x2 <= cfg.wr && y2 >= cfg.wb && y2 <= cfg.wt;
    side_next.degen = cfg.wl == cfg.wr || cfg.wb == cfg.wt;
    side_next.en[0] = dx != '0 && lcvm_pkg::between(x1, x2, cfg.wl);
    side_next.en[1] = dx != '0 && lcvm_pkg::between(x1, x2, cfg.wr);
    side_next.en[2] = dy != '0 && lcvm_pkg::between(y1, y2, cfg.wb);
    side_next.en[3] = dy != '0 && lcvm_pkg::between(y1, y2, cfg.wt);
    side_next.neg[0] = t[0][lcvm_pkg::DB-1] ^ dy[lcvm_pkg::DB-1] ^ dx[lcvm_pkg::DB-1];
    side_next.neg[1] = t[1][lcvm_pkg::DB-1] ^ dy[lcvm_pkg::DB-1] ^ dx[lcvm_pkg::DB-1];
    side_next.neg[2] = t[2][lcvm_pkg::DB-1] ^ dx[lcvm_pkg::DB-1] ^ dy[lcvm_pkg::DB-1];
    side_next.neg[3] = t[3][lcvm_pkg::DB-1] ^ dx[lcvm_pkg::DB-1] ^ dy[lcvm_pkg::DB-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side <= side_next;
    num[0] <= lcvm_pkg::PB'(lcvm_pkg::mag(t[0])) * lcvm_pkg::PB'(mdy);
    num[1] <= lcvm_pkg::PB'(lcvm_pkg::mag(t[1])) * lcvm_pkg::PB'(mdy);
    num[2] <= lcvm_pkg::PB'(lcvm_pkg::mag(t[2])) * lcvm_pkg::PB'(mdx);
    num[3] <= lcvm_pkg::PB'(lcvm_pkg::mag(t[3])) * lcvm_pkg::PB'(mdx);
    den[0] <= mdx;
    den[1] <= mdx;
    den[2] <= mdy;
    den[3] <= mdy;
  end

endmodule

// ===== rtl/lcvm_sel.sv =====
// Candidate point selection followed by the device mapping numerators.
module lcvm_sel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  lcvm_pkg::side_t                   side,
  input  logic [3:0][lcvm_pkg::PB-1:0]      quo,
  input  lcvm_pkg::cfg_t                    cfg,
  output logic                              out_valid,
  output lcvm_pkg::sel_t                    sel,
  output logic [3:0][lcvm_pkg::PB-1:0]      num
);

  logic signed [lcvm_pkg::PB:0]   qs [4];
  logic signed [lcvm_pkg::SW-1:0] c [4];
  logic signed [lcvm_pkg::SW-1:0] lo [4];
  logic signed [lcvm_pkg::SW-1:0] hi [4];
  logic [lcvm_pkg::CB-1:0]        base [4];
  logic [lcvm_pkg::CB-1:0]        cx [6];
  logic [lcvm_pkg::CB-1:0]        cy [6];
  logic [5:0]                     cv;
  logic [1:0]                     n;
  lcvm_pkg::sel_t                 sel_next;
  lcvm_pkg::sel_t                 sa;
  logic                           va;

  always_comb begin
    base[0] = side.y1;
    base[1] = side.y1;
    base[2] = side.x1;
    base[3] = side.x1;
    lo[0] = $signed({{(lcvm_pkg::SW-lcvm_pkg::CB){1'b0}}, cfg.wb});
    hi[0] = $signed({{(lcvm_pkg::SW-lcvm_pkg::CB){1'b0}}, cfg.wt});
    lo[2] = $signed({{(lcvm_pkg::SW-lcvm_pkg::CB){1'b0}}, cfg.wl});
    hi[2] = $signed({{(lcvm_pkg::SW-lcvm_pkg::CB){1'b0}}, cfg.wr});
    lo[1] = lo[0];
    hi[1] = hi[0];
    lo[3] = lo[2];
    hi[3] = hi[2];
    for (int k = 0; k < 4; k++) begin
      qs[k] = side.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      c[k] = $signed({{(lcvm_pkg::SW-lcvm_pkg::PB-1){qs[k][lcvm_pkg::PB]}}, qs[k]})
           + $signed({{(lcvm_pkg::SW-lcvm_pkg::CB){1'b0}}, base[k]});
    end
    cx[0] = side.x1;
    cy[0] = side.y1;
    cx[1] = side.x2;
    cy[1] = side.y2;
    cx[2] = cfg.wl;
    cy[2] = c[0][lcvm_pkg::CB-1:0];
    cx[3] = cfg.wr;
    cy[3] = c[1][lcvm_pkg::CB-1:0];
    cx[4] = c[2][lcvm_pkg::CB-1:0];
    cy[4] = cfg.wb;
    cx[5] = c[3][lcvm_pkg::CB-1:0];
    cy[5] = cfg.wt;
    cv[0] = side.in1;
    cv[1] = side.in2 && side.op == lcvm_pkg::OP_LINE;
    for (int k = 0; k < 4; k++) begin
      cv[k+2] = side.op == lcvm_pkg::OP_LINE && side.en[k] && c[k] >= lo[k] && c[k] <= hi[k];
    end
    n = 2'd0;
    sel_next.p0x = '0;
    sel_next.p0y = '0;
    sel_next.p1x = '0;
    sel_next.p1y = '0;
    for (int i = 0; i < 6; i++) begin
      if (cv[i]) begin
        if (n == 2'd0) begin
          sel_next.p0x = cx[i];
          sel_next.p0y = cy[i];
        end else if (n == 2'd1) begin
          sel_next.p1x = cx[i];
          sel_next.p1y = cy[i];
        end
        if (n != 2'd2) begin
          n = n + 2'd1;
        end
      end
    end
    sel_next.op = side.op;
    if (side.op == lcvm_pkg::OP_POINT) begin
      sel_next.vis = side.in1 && !side.degen;
    end else begin
      sel_next.vis = n == 2'd2 && !side.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    sa <= sel_next;
    sel <= sa;
    num[0] <= lcvm_pkg::PB'(sa.p0x - cfg.wl) * lcvm_pkg::PB'(cfg.dwm);
    num[1] <= lcvm_pkg::PB'(cfg.wt - sa.p0y) * lcvm_pkg::PB'(cfg.dhm);
    num[2] <= lcvm_pkg::PB'(sa.p1x - cfg.wl) * lcvm_pkg::PB'(cfg.dwm);
    num[3] <= lcvm_pkg::PB'(cfg.wt - sa.p1y) * lcvm_pkg::PB'(cfg.dhm);
  end

endmodule

// ===== rtl/line_clip_viewport_map_top.sv =====
// Top level of the line clip and viewport map block: registers, pipeline and outputs.
// A start reaches done through the input, setup, crossing divider, selection, mapping divider and done registers.
// Throughput: one item per cycle; busy stays low and results never stall.
// Depth is set by two banks of four pipelined 24-stage dividers: edge crossings, then device mapping.
// Reset clears the valid bits of every stage and loads the register defaults.
module line_clip_viewport_map_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [lcvm_pkg::CB-1:0]        start_x,
  input  logic [lcvm_pkg::CB-1:0]        start_y,
  input  logic [lcvm_pkg::CB-1:0]        end_x,
  input  logic [lcvm_pkg::CB-1:0]        end_y,
  output logic                           done,
  output logic                           visible,
  output logic [lcvm_pkg::CB-1:0]        dev_start_x,
  output logic [lcvm_pkg::CB-1:0]        dev_start_y,
  output logic [lcvm_pkg::CB-1:0]        dev_end_x,
  output logic [lcvm_pkg::CB-1:0]        dev_end_y,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcvm_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [lcvm_pkg::CB-1:0]        cfg_data
);

  lcvm_pkg::cfg_t                           cfg;
  logic                                     v1;
  logic                                     op1;
  logic [lcvm_pkg::CB-1:0]                  x1, y1, x2, y2;
  logic                                     v2;
  lcvm_pkg::side_t                          side2;
  logic [3:0][lcvm_pkg::PB-1:0]             xnum, xquo, mnum, mquo;
  logic [3:0][lcvm_pkg::CB-1:0]             xden, mden;
  lcvm_pkg::side_t [lcvm_pkg::DIV_LAT-1:0]  sd;
  logic [lcvm_pkg::DIV_LAT-1:0]             vd;
  logic                                     vs;
  lcvm_pkg::sel_t                           sel;
  lcvm_pkg::sel_t [lcvm_pkg::DIV_LAT-1:0]   md;
  logic [lcvm_pkg::DIV_LAT-1:0]             vm;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wl <= lcvm_pkg::CB'(0);
      cfg.wr <= lcvm_pkg::CB'(4095);
      cfg.wb <= lcvm_pkg::CB'(0);
      cfg.wt <= lcvm_pkg::CB'(3071);
      cfg.dwm <= lcvm_pkg::CB'(639);
      cfg.dhm <= lcvm_pkg::CB'(479);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcvm_pkg::REG_WINDOW_LEFT: cfg.wl <= cfg_data;
        lcvm_pkg::REG_WINDOW_RIGHT: cfg.wr <= cfg_data;
        lcvm_pkg::REG_WINDOW_BOTTOM: cfg.wb <= cfg_data;
        lcvm_pkg::REG_WINDOW_TOP: cfg.wt <= cfg_data;
        lcvm_pkg::REG_DEVICE_WIDTH_MAX: cfg.dwm <= cfg_data;
        lcvm_pkg::REG_DEVICE_HEIGHT_MAX: cfg.dhm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= op;
    x1 <= start_x;
    y1 <= start_y;
    x2 <= end_x;
    y2 <= end_y;
  end

  lcvm_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .op        (op1),
    .x1        (x1),
    .y1        (y1),
    .x2        (x2),
    .y2        (y2),
    .cfg       (cfg),
    .out_valid (v2),
    .side      (side2),
    .num       (xnum),
    .den       (xden)
  );

  for (genvar k = 0; k < 4; k++) begin : g_xdiv
    lcvm_div u_div (
      .clk (clk),
      .num (xnum[k]),
      .den (xden[k]),
      .quo (xquo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
      vm <= '0;
    end else begin
      vd <= {vd[lcvm_pkg::DIV_LAT-2:0], v2};
      vm <= {vm[lcvm_pkg::DIV_LAT-2:0], vs};
    end
  end

  always_ff @(posedge clk) begin
    sd <= {sd[lcvm_pkg::DIV_LAT-2:0], side2};
    md <= {md[lcvm_pkg::DIV_LAT-2:0], sel};
  end

  lcvm_sel u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd[lcvm_pkg::DIV_LAT-1]),
    .side      (sd[lcvm_pkg::DIV_LAT-1]),
    .quo       (xquo),
    .cfg       (cfg),
    .out_valid (vs),
    .sel       (sel),
    .num       (mnum)
  );

  assign mden[0] = cfg.wr - cfg.wl;
  assign mden[1] = cfg.wt - cfg.wb;
  assign mden[2] = cfg.wr - cfg.wl;
  assign mden[3] = cfg.wt - cfg.wb;

  for (genvar k = 0; k < 4; k++) begin : g_mdiv
    lcvm_div u_div (
      .clk (clk),
      .num (mnum[k]),
      .den (mden[k]),
      .quo (mquo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vm[lcvm_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    visible <= md[lcvm_pkg::DIV_LAT-1].vis;
    if (md[lcvm_pkg::DIV_LAT-1].vis) begin
      dev_start_x <= mquo[0][lcvm_pkg::CB-1:0];
      dev_start_y <= mquo[1][lcvm_pkg::CB-1:0];
    end else begin
      dev_start_x <= '0;
      dev_start_y <= '0;
    end
    if (md[lcvm_pkg::DIV_LAT-1].vis && md[lcvm_pkg::DIV_LAT-1].op == lcvm_pkg::OP_LINE) begin
      dev_end_x <= mquo[2][lcvm_pkg::CB-1:0];
      dev_end_y <= mquo[3][lcvm_pkg::CB-1:0];
    end else begin
      dev_end_x <= '0;
      dev_end_y <= '0;
    end
  end

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, lcvm_pkg::LATENCY))
    else $error("Result strobe without a matching start transfer.");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> dev_start_x == '0 && dev_start_y == '0 &&
                         dev_end_x == '0 && dev_end_y == '0)
    else $error("Invisible result carries nonzero coordinates.");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    vs |-> $past(vd[lcvm_pkg::DIV_LAT-1], 2))
    else $error("Selection stage valid without an item from the crossing dividers.");

endmodule
